// File: design/kec_pkg.sv
`default_nettype none
package kec_pkg;
   localparam int TABLE_ENTRIES = 1024;
   localparam int SLOT_BITS = $clog2(TABLE_ENTRIES);
   localparam int MAX_PREFIX_BASES = 32;
   localparam int COUNT_WIDTH = 32;
   localparam int CNT_ADDR_BITS = SLOT_BITS + 2;
   localparam int CNT_DEPTH = 4 * TABLE_ENTRIES;
   localparam int SEARCH_STEPS = SLOT_BITS + 1;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_BASE  = 2'd1,
      OP_BREAK = 2'd2,
      OP_DUMP  = 2'd3
   } opcode_type;

   localparam logic CSR_PREFIX_LENGTH = 1'b0;
   localparam logic CSR_ENTRIES = 1'b1;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [9:0]  slot;
      logic [63:0] prefix_value;
      logic [7:0]  base_char;
   } req_type;

   typedef struct packed {
      logic [9:0]  dump_slot;
      logic [1:0]  extension_base;
      logic [31:0] extension_count;
      logic        significant;
      logic        last_of_dump;
   } rsp_type;

   // one search cell: lower-bound window handed down the row
   typedef struct packed {
      logic        active;
      logic [10:0] lo;
      logic [10:0] hi;
   } search_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_LOAD, ST_SEARCH, ST_SREAD, ST_SCMP, ST_FINAL,
      ST_FREAD, ST_FCMP, ST_INC, ST_DREAD, ST_DOUT
   } state_type;
endpackage
`default_nettype wire

// File: design/kec_ram.sv
`default_nettype none
module kec_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      rdata <= mem_ff[raddr];
   end
endmodule
`default_nettype wire

// File: design/kec_search_cell.sv
`default_nettype none
module kec_search_cell
   import kec_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire search_type prev,
   input  wire logic       less,
   output search_type      cur,
   output logic [10:0]     mid
);
   search_type cur_ff, cur_in;
   assign mid = prev.lo + ((prev.hi - prev.lo) >> 1);
   always_comb begin
      cur_in = cur_ff;
      if (step) begin
         cur_in = prev;
         if (prev.active && prev.lo < prev.hi) begin
            if (less) cur_in.lo = mid + 11'd1;
            else cur_in.hi = mid;
         end
      end
   end
   always_ff @(posedge clock) begin
      if (reset) cur_ff <= '0;
      else cur_ff <= cur_in;
   end
   assign cur = cur_ff;
endmodule
`default_nettype wire

// File: design/kmer_extension_counter.sv
`default_nettype none
// kmer extension counter
// req channel (valid/stall) carries load, base, break and dump transactions;
// rsp channel (valid/stall) returns four counts per dump, last_of_dump on the
// fourth. csr port writes prefix_length (index 0) and entries_in_use (index 1);
// the user must do so only while the block is idle, which it does not enforce.
// one transaction is taken at a time. load: table write with the first of four
// counter clears. base: per search cell a table read, compare and cell step
// (11 cells), plus a final read and compare, then the counter read-modify-write
// of a hit; a base with no full window or a non-ACGT character skips the search.
// dump: a counter read and an rsp write per count; the rsp register holds its
// transaction while stalled and the block waits. after reset the counter store
// (4096 entries) is swept to zero, one entry a cycle, with req stalled; csr
// writes are taken throughout.
module kmer_extension_counter
   import kec_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [10:0] csr_wdata
);
   state_type state_ff, state_in;
   logic [5:0]  plen_ff;
   logic [10:0] nent_ff;
   logic [63:0] hist_ff, hist_in;
   logic [5:0]  run_ff, run_in;
   req_type     cur_ff, cur_in;
   logic [CNT_ADDR_BITS-1:0] caddr_ff, caddr_in;
   logic [SLOT_BITS-1:0] hit_ff, hit_in;
   logic [3:0]  cell_ff, cell_in;
   logic [1:0]  kk_ff, kk_in;
   logic        less_ff, less_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic [5:0]  len;
   logic [63:0] mask, key;
   logic [2:0]  bcode;
   always_comb begin
      len = (plen_ff == 6'd0) ? 6'd1 :
            (plen_ff > 6'(MAX_PREFIX_BASES)) ? 6'(MAX_PREFIX_BASES) : plen_ff;
      mask = 64'hFFFF_FFFF_FFFF_FFFF >> (7'd64 - {len, 1'b0});
      key = hist_ff & mask;
      case (cur_ff.base_char)
         8'h41, 8'h61: bcode = 3'd0;
         8'h43, 8'h63: bcode = 3'd1;
         8'h47, 8'h67: bcode = 3'd2;
         8'h54, 8'h74: bcode = 3'd3;
         default: bcode = 3'd4;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff <= 6'd16;
         nent_ff <= '0;
      end else if (csr_we) begin
         if (csr_index == CSR_PREFIX_LENGTH) plen_ff <= csr_wdata[5:0];
         else nent_ff <= csr_wdata;
      end
   end

   // row of search cells
   search_type chain [SEARCH_STEPS+1];
   logic [10:0] mids [SEARCH_STEPS];
   logic [SEARCH_STEPS-1:0] steps;
   logic [10:0] nclip;
   assign nclip = (nent_ff > 11'(TABLE_ENTRIES)) ? 11'(TABLE_ENTRIES) : nent_ff;
   assign chain[0] = {1'b1, 11'd0, nclip};
   for (genvar i = 0; i < SEARCH_STEPS; i++) begin : g_cell
      assign steps[i] = (state_ff == ST_FINAL) && (cell_ff == 4'(i));
      kec_search_cell u_cell (
         .clock(clock), .reset(reset), .step(steps[i]), .prev(chain[i]),
         .less(less_ff), .cur(chain[i+1]), .mid(mids[i])
      );
   end
   search_type last;
   assign last = chain[SEARCH_STEPS];

   // memories
   logic tab_we;
   logic [SLOT_BITS-1:0] tab_raddr;
   logic [63:0] tab_rdata;
   logic cnt_we;
   logic [COUNT_WIDTH-1:0] cnt_wdata, cnt_rdata;
   kec_ram #(.WIDTH(64), .DEPTH(TABLE_ENTRIES)) u_tab (
      .clock(clock), .we(tab_we), .waddr(cur_ff.slot), .wdata(cur_ff.prefix_value),
      .raddr(tab_raddr), .rdata(tab_rdata)
   );
   kec_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(CNT_DEPTH)) u_cnt (
      .clock(clock), .we(cnt_we), .waddr(caddr_ff), .wdata(cnt_wdata),
      .raddr(caddr_ff), .rdata(cnt_rdata)
   );

   logic [10:0] mid_sel;
   always_comb begin
      mid_sel = '0;
      for (int i = 0; i < SEARCH_STEPS; i++)
         if (cell_ff == 4'(i)) mid_sel = mids[i];
   end

   always_comb begin
      state_in = state_ff;
      hist_in = hist_ff;
      run_in = run_ff;
      cur_in = cur_ff;
      caddr_in = caddr_ff;
      hit_in = hit_ff;
      cell_in = cell_ff;
      kk_in = kk_ff;
      less_in = less_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in = rsp_ff;
      req_stall = 1'b1;
      tab_we = 1'b0;
      tab_raddr = mid_sel[SLOT_BITS-1:0];
      cnt_we = 1'b0;
      cnt_wdata = '0;
      case (state_ff)
         ST_CLEAR: begin
            cnt_we = 1'b1;
            caddr_in = caddr_ff + 1'b1;
            if (caddr_ff == CNT_ADDR_BITS'(CNT_DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cur_in = req_data;
               case (opcode_type'(req_data.opcode))
                  OP_LOAD: begin
                     caddr_in = {req_data.slot, 2'd0};
                     state_in = ST_LOAD;
                  end
                  OP_BASE: state_in = ST_SEARCH;
                  OP_BREAK: run_in = '0;
                  OP_DUMP: begin
                     kk_in = '0;
                     caddr_in = {req_data.slot, 2'd0};
                     state_in = ST_DREAD;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_LOAD: begin
            tab_we = (caddr_ff[1:0] == 2'd0);
            cnt_we = 1'b1;
            caddr_in = caddr_ff + 1'b1;
            if (caddr_ff[1:0] == 2'd3) state_in = ST_IDLE;
         end
         ST_SEARCH: begin
            cell_in = '0;
            if (bcode[2]) begin
               run_in = '0;
               state_in = ST_IDLE;
            end else if (run_ff >= len) begin
               state_in = ST_SREAD;
            end else begin
               hist_in = {hist_ff[61:0], bcode[1:0]};
               if (run_ff < 6'(MAX_PREFIX_BASES)) run_in = run_ff + 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SREAD: state_in = ST_SCMP; // table read at cell midpoint
         ST_SCMP: begin
            less_in = (tab_rdata & mask) < key;
            state_in = ST_FINAL;
         end
         ST_FINAL: begin
            // cell stepped with the registered compare of the previous cycle
            if (cell_ff == 4'(SEARCH_STEPS - 1)) begin
               state_in = ST_FREAD;
            end else begin
               cell_in = cell_ff + 1'b1;
               state_in = ST_SREAD;
            end
         end
         ST_FREAD: begin
            tab_raddr = last.lo[SLOT_BITS-1:0];
            state_in = ST_FCMP;
         end
         ST_FCMP: begin
            tab_raddr = last.lo[SLOT_BITS-1:0];
            hist_in = {hist_ff[61:0], bcode[1:0]};
            if (run_ff < 6'(MAX_PREFIX_BASES)) run_in = run_ff + 1'b1;
            if (last.lo < nclip && (tab_rdata & mask) == key) begin
               hit_in = last.lo[SLOT_BITS-1:0];
               caddr_in = {last.lo[SLOT_BITS-1:0], bcode[1:0]};
               state_in = ST_INC;
            end else state_in = ST_IDLE;
         end
         ST_INC: begin
            state_in = ST_DOUT; // wait for read
            kk_in = 2'd0;
         end
         ST_DREAD: state_in = ST_DOUT;
         ST_DOUT: begin
            if (cur_ff.opcode == OP_BASE) begin
               cnt_we = (cnt_rdata != '1);
               cnt_wdata = cnt_rdata + 1'b1;
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in.dump_slot = cur_ff.slot;
               rsp_in.extension_base = kk_ff;
               rsp_in.extension_count = cnt_rdata;
               rsp_in.significant = cnt_rdata > 32'd1;
               rsp_in.last_of_dump = (kk_ff == 2'd3);
               kk_in = kk_ff + 1'b1;
               caddr_in = caddr_ff + 1'b1;
               state_in = (kk_ff == 2'd3) ? ST_IDLE : ST_DREAD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         hist_ff <= '0;
         run_ff <= '0;
         caddr_ff <= '0;
         cell_ff <= '0;
         kk_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         hist_ff <= hist_in;
         run_ff <= run_in;
         caddr_ff <= caddr_in;
         cell_ff <= cell_in;
         kk_ff <= kk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff <= cur_in;
      hit_ff <= hit_in;
      less_ff <= less_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> req_stall) else $error("req taken during clear");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed while stalled");
   a_hit_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_INC |-> 11'(hit_ff) < nclip) else $error("hit beyond table");
endmodule
`default_nettype wire

// File: sim/kmer_extension_counter_tb.sv
`default_nettype none
module kmer_extension_counter_tb;
   import kec_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES = 80;
   localparam int WATCHDOG_LIMIT = 30000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;
   logic csr_we;
   logic csr_index;
   logic [10:0] csr_wdata;

   kmer_extension_counter dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // predictor state
   logic [5:0]  model_plen;
   logic [10:0] model_entries;
   logic [63:0] model_history;
   int unsigned model_run;
   logic [63:0] model_table [TABLE_ENTRIES];
   logic [31:0] model_counts [CNT_DEPTH];

   rsp_type pending_counts [$];
   bit [63:0] slot_keys [$];
   int unsigned mismatches;
   int unsigned items_sent;
   int unsigned dumps_seen;
   int unsigned hits_seen;
   int unsigned rsp_seen;
   int unsigned idle_cycles;
   int unsigned stall_left;
   bit quiet;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned eff_len(input logic [5:0] pl);
      if (pl == 0) return 1;
      if (pl > MAX_PREFIX_BASES) return MAX_PREFIX_BASES;
      return pl;
   endfunction

   function automatic logic [63:0] len_mask(input int unsigned len);
      if (len >= 32) return '1;
      return (64'd1 << (2 * len)) - 64'd1;
   endfunction

   function automatic int base_of(input logic [7:0] ch);
      case (ch)
         "A", "a": return 0;
         "C", "c": return 1;
         "G", "g": return 2;
         "T", "t": return 3;
         default: return -1;
      endcase
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic predict_counts(input req_type t);
      int b;
      int unsigned len, n, lo, hi, mid, idx;
      logic [63:0] m, key;
      rsp_type r;
      case (opcode_type'(t.opcode))
         OP_LOAD: begin
            model_table[t.slot] = t.prefix_value;
            for (int k = 0; k < 4; k++) model_counts[4 * t.slot + k] = '0;
         end
         OP_BREAK: model_run = 0;
         OP_BASE: begin
            b = base_of(t.base_char);
            len = eff_len(model_plen);
            if (b < 0) begin
               model_run = 0;
            end else begin
               if (model_run >= len) begin
                  m = len_mask(len);
                  key = model_history & m;
                  n = (model_entries > TABLE_ENTRIES) ? TABLE_ENTRIES : model_entries;
                  lo = 0;
                  hi = n;
                  while (lo < hi) begin
                     mid = lo + (hi - lo) / 2;
                     if ((model_table[mid] & m) < key) lo = mid + 1;
                     else hi = mid;
                  end
                  if (lo < n && (model_table[lo] & m) == key) begin
                     idx = 4 * lo + b;
                     hits_seen++;
                     if (model_counts[idx] != '1) model_counts[idx]++;
                  end
               end
               model_history = (model_history << 2) | 64'(b);
               if (model_run < MAX_PREFIX_BASES) model_run++;
            end
         end
         default: begin
            dumps_seen++;
            for (int k = 0; k < 4; k++) begin
               r.dump_slot = t.slot;
               r.extension_base = 2'(k);
               r.extension_count = model_counts[4 * t.slot + k];
               r.significant = model_counts[4 * t.slot + k] > 1;
               r.last_of_dump = (k == 3);
               pending_counts.push_back(r);
            end
         end
      endcase
   endtask

   task automatic report(input string what);
      mismatches++;
      $display("mismatch at %0t: %s", $time, what);
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         if (pending_counts.size() == 0) begin
            report($sformatf("unexpected count slot %0d", rsp_data.dump_slot));
         end else begin
            if (rsp_data.dump_slot !== pending_counts[0].dump_slot)
               report($sformatf("dump_slot %0d want %0d", rsp_data.dump_slot,
                  pending_counts[0].dump_slot));
            if (rsp_data.extension_base !== pending_counts[0].extension_base)
               report($sformatf("extension_base %0d want %0d", rsp_data.extension_base,
                  pending_counts[0].extension_base));
            if (rsp_data.extension_count !== pending_counts[0].extension_count)
               report($sformatf("slot %0d base %0d count %0d want %0d",
                  pending_counts[0].dump_slot, pending_counts[0].extension_base,
                  rsp_data.extension_count, pending_counts[0].extension_count));
            if (rsp_data.significant !== pending_counts[0].significant)
               report($sformatf("significant %0b want %0b", rsp_data.significant,
                  pending_counts[0].significant));
            if (rsp_data.last_of_dump !== pending_counts[0].last_of_dump)
               report($sformatf("last_of_dump %0b want %0b", rsp_data.last_of_dump,
                  pending_counts[0].last_of_dump));
            void'(pending_counts.pop_front());
         end
      end
   end

   // receiver stall bursts
   always @(posedge clock) begin
      if (quiet) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
         stall_left = $urandom_range(0, 14);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d counts outstanding", pending_counts.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic req_type make_req(input opcode_type op, input logic [9:0] slot,
                                        input logic [63:0] pv, input logic [7:0] ch);
      req_type t;
      t.opcode = op;
      t.slot = slot;
      t.prefix_value = pv;
      t.base_char = ch;
      return t;
   endfunction

   // called at a rising edge; returns at the accepting edge, or after a gap
   task automatic send_item(input req_type t);
      req_valid <= 1'b1;
      req_data <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      predict_counts(t);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         req_data <= make_req(opcode_type'($urandom_range(0, 3)), 10'($urandom),
            rand64(), 8'($urandom));
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_counts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [10:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_PREFIX_LENGTH) model_plen = value[5:0];
      else model_entries = value;
   endtask

   function automatic logic [7:0] base_char_of(input int b);
      logic [7:0] up;
      case (b)
         0: up = "A";
         1: up = "C";
         2: up = "G";
         default: up = "T";
      endcase
      return $urandom_range(0, 1) ? up : (up | 8'h20);
   endfunction

   function automatic logic [7:0] noise_char();
      logic [7:0] ch;
      do ch = 8'($urandom); while (base_of(ch) >= 0);
      return ch;
   endfunction

   // loads slots 0..n-1; keys are masked, stored values get random upper bits
   task automatic load_table(input int n, input bit sorted, input bit dup);
      logic [63:0] m;
      m = len_mask(eff_len(model_plen));
      slot_keys.delete();
      for (int i = 0; i < n; i++) slot_keys.push_back(rand64() & m);
      if (dup && n > 2) slot_keys[2] = slot_keys[1];
      if (sorted) slot_keys.sort();
      for (int i = 0; i < n; i++)
         send_item(make_req(OP_LOAD, 10'(i), (rand64() & ~m) | slot_keys[i], 8'($urandom)));
   endtask

   // mostly prefixes from the table followed by one base, plus noise
   task automatic stream_bases(input int count);
      int sent, r, s, len;
      logic [63:0] key;
      sent = 0;
      len = eff_len(model_plen);
      while (sent < count) begin
         r = $urandom_range(0, 99);
         s = $urandom_range(0, slot_keys.size() - 1);
         if (r < 65) begin
            key = slot_keys[s];
            for (int i = len - 1; i >= 0; i--)
               send_item(make_req(OP_BASE, 10'($urandom), rand64(),
                  base_char_of(int'((key >> (2 * i)) & 64'd3))));
            send_item(make_req(OP_BASE, 10'($urandom), rand64(),
               base_char_of($urandom_range(0, 3))));
            sent += len + 1;
         end else begin
            if (r < 80)
               send_item(make_req(OP_BASE, 10'($urandom), rand64(),
                  base_char_of($urandom_range(0, 3))));
            else if (r < 87)
               send_item(make_req(OP_BASE, 10'($urandom), rand64(), noise_char()));
            else if (r < 92)
               send_item(make_req(OP_BREAK, 10'($urandom), rand64(), 8'($urandom)));
            else if (r < 97)
               send_item(make_req(OP_DUMP, 10'(s), rand64(), 8'($urandom)));
            else
               send_item(make_req(OP_LOAD, 10'(s), model_table[s], 8'($urandom)));
            sent++;
         end
      end
   endtask

   task automatic dump_slots(input int n);
      for (int i = 0; i < n; i++)
         send_item(make_req(OP_DUMP, 10'(i), rand64(), 8'($urandom)));
   endtask

   task automatic test_directed();
      // no table searched: bases just fill the window
      send_item(make_req(OP_BASE, 10'd0, 64'd0, "G"));
      send_item(make_req(OP_DUMP, 10'd1023, '1, 8'hff));
      settle();
      write_csr(CSR_PREFIX_LENGTH, 11'd1);
      for (int i = 0; i < 4; i++)
         send_item(make_req(OP_LOAD, 10'(i), (rand64() & ~64'd3) | 64'(i), 8'd0));
      settle();
      write_csr(CSR_ENTRIES, 11'd4);
      send_item(make_req(OP_BASE, 10'd0, 64'd0, "A"));
      send_item(make_req(OP_BASE, 10'd0, 64'd0, "A"));
      send_item(make_req(OP_BASE, 10'd0, 64'd0, "c"));
      send_item(make_req(OP_BASE, 10'd0, 64'd0, "g"));
      send_item(make_req(OP_BASE, 10'd0, 64'd0, "x"));
      send_item(make_req(OP_BASE, 10'd0, 64'd0, "T"));
      send_item(make_req(OP_BASE, 10'd0, 64'd0, "t"));
      send_item(make_req(OP_BREAK, 10'd0, 64'd0, "t"));
      send_item(make_req(OP_BASE, 10'd0, 64'd0, "C"));
      send_item(make_req(OP_BASE, 10'd0, 64'd0, "C"));
      send_item(make_req(OP_BASE, 10'd0, 64'd0, "C"));
      dump_slots(4);
      send_item(make_req(OP_LOAD, 10'd1, 64'd1, 8'd0));
      send_item(make_req(OP_DUMP, 10'd1, 64'd0, 8'd0));
      settle();
   endtask

   task automatic test_length(input logic [5:0] pl, input int n, input bit sorted,
                              input bit dup, input int count);
      write_csr(CSR_PREFIX_LENGTH, 11'(pl));
      load_table(n, sorted, dup);
      settle();
      write_csr(CSR_ENTRIES, 11'(n));
      stream_bases(count);
      dump_slots(n);
      settle();
   endtask

   // search over the whole table: slots on the rightmost path hold A, the top
   // slot holds T, and only C, G and T are streamed so the search keeps right
   task automatic test_full_table();
      write_csr(CSR_PREFIX_LENGTH, 11'd1);
      send_item(make_req(OP_LOAD, 10'd0, rand64() & ~64'd3, 8'($urandom)));
      for (int k = 9; k >= 1; k--)
         send_item(make_req(OP_LOAD, 10'(1024 - (1 << k)), rand64() & ~64'd3,
            8'($urandom)));
      send_item(make_req(OP_LOAD, 10'd1023, rand64() | 64'd3, 8'($urandom)));
      settle();
      // beyond the table size saturates
      write_csr(CSR_ENTRIES, 11'h7ff);
      send_item(make_req(OP_BREAK, 10'($urandom), rand64(), 8'($urandom)));
      for (int i = 0; i < 16; i++)
         send_item(make_req(OP_BASE, 10'($urandom), rand64(),
            base_char_of($urandom_range(1, 3))));
      send_item(make_req(OP_DUMP, 10'd1023, rand64(), 8'($urandom)));
      settle();
      write_csr(CSR_ENTRIES, 11'd1024);
      for (int i = 0; i < 10; i++)
         send_item(make_req(OP_BASE, 10'($urandom), rand64(),
            base_char_of($urandom_range(1, 3))));
      send_item(make_req(OP_DUMP, 10'd1023, rand64(), 8'($urandom)));
      send_item(make_req(OP_DUMP, 10'd512, rand64(), 8'($urandom)));
      settle();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_we = 1'b0;
      csr_index = 1'b0;
      csr_wdata = '0;
      quiet = 1'b0;
      mismatches = 0;
      items_sent = 0;
      dumps_seen = 0;
      hits_seen = 0;
      rsp_seen = 0;
      idle_cycles = 0;
      stall_left = 0;
      model_plen = 6'd16;
      model_entries = '0;
      model_history = '0;
      model_run = 0;
      for (int i = 0; i < TABLE_ENTRIES; i++) model_table[i] = '0;
      for (int i = 0; i < CNT_DEPTH; i++) model_counts[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_length(6'd2, 6, 1'b1, 1'b0, 50);
      test_length(6'd16, 8, 1'b1, 1'b1, 50);
      test_length(6'd32, 5, 1'b1, 1'b0, 50);
      test_length(6'd0, 4, 1'b1, 1'b0, 30);
      test_length(6'd40, 4, 1'b1, 1'b0, 30);
      test_length(6'd3, 8, 1'b0, 1'b1, 40);
      test_full_table();
      quiet = 1'b1;
      test_length(6'd63, 3, 1'b1, 1'b0, 40);
      test_length(6'd4, 0, 1'b1, 1'b0, 0);

      settle();
      $display("sent %0d transactions: %0d dumps, %0d counted extensions, %0d counts checked",
         items_sent, dumps_seen, hits_seen, rsp_seen);
      $display("prefix lengths 0 to 63, 0 to 8 slots searched plus full-depth searches");
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
`default_nettype wire

// File: files.f
design/kec_pkg.sv
design/kec_ram.sv
design/kec_search_cell.sv
design/kmer_extension_counter.sv
sim/kmer_extension_counter_tb.sv
